FILE: design/bba_pkg.sv
// Shared constants, codes and types of the buddy block allocator.
package bba_pkg;

    localparam int BLOCK_COUNT = 1024;
    localparam int MAX_ORDER   = 10;
    localparam int NUM_LISTS   = MAX_ORDER + 1;
    localparam int IDX_W       = $clog2(BLOCK_COUNT);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ORD_W       = 4;
    localparam int TAG_W       = $clog2(MAX_ORDER + 2);
    localparam int STAT_W      = 3;

    localparam logic [CNT_W-1:0] NIL_LINK = CNT_W'(BLOCK_COUNT);

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_INIT  = 3'd1,
        ST_BAD_ORDER = 3'd2,
        ST_NO_MEM    = 3'd3,
        ST_BAD_INDEX = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_CLEAR,
        OP_CARVE,
        OP_INIT_END,
        OP_APP_UNL,
        OP_APP_LINK,
        OP_APP_TAIL,
        OP_UNLINK,
        OP_SPLIT,
        OP_MAP_START,
        OP_MAPSET,
        OP_FIN,
        OP_SCAN_START,
        OP_SCAN,
        OP_TAG_RD,
        OP_MERGE,
        OP_OUT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CLEAR,
        S_CARVE,
        S_APP_UNL,
        S_APP_LINK,
        S_APP_TAIL,
        S_UNLINK,
        S_SPLIT,
        S_MAPSET,
        S_MRG,
        S_SCAN,
        S_MRG_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        cmd_t cmd;
        logic pre_ok;
        logic clr_last;
        logic carve_end;
        logic split_more;
        logic map_last;
        logic merge_top;
        logic scan_done;
        logic scan_hit;
        logic tag_match;
    } dp_stat_t;

endpackage

FILE: design/buddy_block_allocator.sv
// Buddy block allocator top level: controller, datapath and config register.
//
// Input channel (in_valid/in_ready) takes one word per command: cmd, order,
// block_index. Output channel (out_valid/out_ready) returns one word per
// command: status, result_index, free_units. The config channel
// (cfg_valid/cfg_ready, always ready) writes managed_blocks; it is read by
// init only.
// Commands run one at a time. Init clears the map and tag memories, then
//   carves the region into aligned blocks; alloc splits its block down to
//   the requested order, then writes the map; free writes the map, then
//   merges with the buddy while the buddy's map bits are clear and its tag
//   shows it free at the same order. A rejected command goes to the output.
// After reset the block is not initialized; alloc and free answer
// "not initialized" until an init completes. No sweep runs at reset.
// A finished word waits in the output register while the next command is
// accepted and processed; a stalled receiver holds only the finish step.
module buddy_block_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    cmd,
    input  logic [bba_pkg::ORD_W-1:0]     order,
    input  logic [bba_pkg::IDX_W-1:0]     block_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bba_pkg::STAT_W-1:0]    status,
    output logic [bba_pkg::IDX_W-1:0]     result_index,
    output logic [bba_pkg::CNT_W-1:0]     free_units,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bba_pkg::CNT_W-1:0]     managed_blocks
);
    import bba_pkg::*;

    dp_op_t   op;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .op        (op)
    );

    bba_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .stat           (stat),
        .cfg_valid      (cfg_valid),
        .managed_blocks (managed_blocks),
        .cmd            (cmd),
        .order          (order),
        .block_index    (block_index),
        .status         (status),
        .result_index   (result_index),
        .free_units     (free_units)
    );

endmodule

FILE: design/bba_ctrl.sv
// Controller state machine sequencing the allocator datapath.
module bba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bba_pkg::dp_stat_t stat,
    output bba_pkg::dp_op_t   op
);
    import bba_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op             = OP_NONE;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                op = OP_START;
                if (!stat.pre_ok)
                    state_next = S_DONE;
                else if (stat.cmd == CMD_INIT)
                    state_next = S_CLEAR;
                else if (stat.cmd == CMD_ALLOC)
                    state_next = S_UNLINK;
                else
                    state_next = S_MAPSET;
            end
            S_CLEAR:
            begin
                op = OP_CLEAR;
                if (stat.clr_last)
                    state_next = S_CARVE;
            end
            S_CARVE:
            begin
                if (stat.carve_end)
                begin
                    op         = OP_INIT_END;
                    state_next = S_DONE;
                end
                else
                begin
                    op         = OP_CARVE;
                    state_next = S_APP_UNL;
                end
            end
            S_APP_UNL:
            begin
                op         = OP_APP_UNL;
                state_next = S_APP_LINK;
            end
            S_APP_LINK:
            begin
                op         = OP_APP_LINK;
                state_next = S_APP_TAIL;
            end
            S_APP_TAIL:
            begin
                op = OP_APP_TAIL;
                if (stat.cmd == CMD_INIT)
                    state_next = S_CARVE;
                else if (stat.cmd == CMD_ALLOC)
                    state_next = S_SPLIT;
                else
                    state_next = S_DONE;
            end
            S_UNLINK:
            begin
                op         = OP_UNLINK;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                if (stat.split_more)
                begin
                    op         = OP_SPLIT;
                    state_next = S_APP_UNL;
                end
                else
                begin
                    op         = OP_MAP_START;
                    state_next = S_MAPSET;
                end
            end
            S_MAPSET:
            begin
                op = OP_MAPSET;
                if (stat.map_last)
                    state_next = (stat.cmd == CMD_ALLOC) ? S_DONE : S_MRG;
            end
            S_MRG:
            begin
                if (stat.merge_top)
                begin
                    op         = OP_FIN;
                    state_next = S_APP_UNL;
                end
                else
                begin
                    op         = OP_SCAN_START;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!stat.scan_done)
                    op = OP_SCAN;
                else if (stat.scan_hit)
                begin
                    op         = OP_FIN;
                    state_next = S_APP_UNL;
                end
                else
                begin
                    op         = OP_TAG_RD;
                    state_next = S_MRG_CHK;
                end
            end
            S_MRG_CHK:
            begin
                if (stat.tag_match)
                begin
                    op         = OP_MERGE;
                    state_next = S_MRG;
                end
                else
                begin
                    op         = OP_FIN;
                    state_next = S_APP_UNL;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    op             = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: design/bba_datapath.sv
// Datapath: free lists, link and tag memories, allocation map and counters.
module bba_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bba_pkg::dp_op_t               op,
    output bba_pkg::dp_stat_t             stat,
    input  logic                          cfg_valid,
    input  logic [bba_pkg::CNT_W-1:0]     managed_blocks,
    input  logic [1:0]                    cmd,
    input  logic [bba_pkg::ORD_W-1:0]     order,
    input  logic [bba_pkg::IDX_W-1:0]     block_index,
    output logic [bba_pkg::STAT_W-1:0]    status,
    output logic [bba_pkg::IDX_W-1:0]     result_index,
    output logic [bba_pkg::CNT_W-1:0]     free_units
);
    import bba_pkg::*;

    logic [CNT_W-1:0]  mb_reg;
    cmd_t              cmd_reg;
    logic [ORD_W-1:0]  ord_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  blk_reg;
    logic [IDX_W-1:0]  app_b_reg;
    logic [IDX_W-1:0]  rd_b_reg;
    logic [ORD_W-1:0]  lvl_reg;
    logic [ORD_W-1:0]  app_o_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  size_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  tail_t_reg;
    logic [CNT_W-1:0]  region_reg;
    logic [CNT_W-1:0]  free_reg;
    logic              pend_reg;
    logic              hit_reg;
    logic              ready_reg;
    status_t           status_reg;
    logic [IDX_W-1:0]  result_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [IDX_W-1:0]  out_result_reg;
    logic [CNT_W-1:0]  out_free_reg;
    logic [CNT_W-1:0]  head_reg [NUM_LISTS];
    logic [CNT_W-1:0]  tail_reg [NUM_LISTS];

    logic [CNT_W-1:0]  next_mem [BLOCK_COUNT];
    logic [CNT_W-1:0]  prev_mem [BLOCK_COUNT];
    logic [TAG_W-1:0]  tag_mem  [BLOCK_COUNT];
    logic              map_mem  [BLOCK_COUNT];
    logic [CNT_W-1:0]  rd_next_reg;
    logic [CNT_W-1:0]  rd_prev_reg;
    logic [TAG_W-1:0]  rd_tag_reg;
    logic              map_rd_reg;

    logic [CNT_W-1:0]  size_clamp;
    logic [ORD_W-1:0]  found_c;
    logic              found_any;
    logic [IDX_W-1:0]  ord_mask;
    status_t           pre_status;
    logic [CNT_W-1:0]  n_ord;
    logic [CNT_W-1:0]  n_lvl;
    logic [IDX_W-1:0]  bud;
    logic [IDX_W-1:0]  split_b;
    logic [CNT_W-1:0]  rem;
    logic [ORD_W-1:0]  carve_o;
    logic [CNT_W:0]    free_sum;
    logic [ORD_W-1:0]  ul_o;
    logic              ul_valid;

    logic              nx_we, pv_we, tag_we, map_we, rd_en, map_re;
    logic [IDX_W-1:0]  nx_wa, pv_wa, tag_wa, map_wa, rd_addr, map_ra;
    logic [CNT_W-1:0]  nx_wd, pv_wd;
    logic [TAG_W-1:0]  tag_wd;
    logic              map_wd;

    assign size_clamp = (mb_reg > CNT_W'(BLOCK_COUNT)) ? CNT_W'(BLOCK_COUNT) : mb_reg;
    assign n_ord      = CNT_W'(1) << ord_reg;
    assign n_lvl      = CNT_W'(1) << lvl_reg;
    assign ord_mask   = IDX_W'(n_ord - CNT_W'(1));
    assign bud        = blk_reg ^ IDX_W'(n_lvl);
    assign split_b    = blk_reg + IDX_W'(n_lvl >> 1);
    assign rem        = size_reg - pos_reg;
    assign free_sum   = {1'b0, free_reg} + {1'b0, n_ord};
    assign ul_o       = rd_tag_reg - TAG_W'(1);
    assign ul_valid   = (rd_tag_reg != '0) && (ul_o <= ORD_W'(MAX_ORDER));

    // lowest nonempty list at or above the requested order
    always_comb
    begin
        found_c   = '0;
        found_any = 1'b0;
        for (int o = MAX_ORDER; o >= 0; o--)
        begin
            if (ORD_W'(o) >= ord_reg && head_reg[o] != NIL_LINK)
            begin
                found_c   = ORD_W'(o);
                found_any = 1'b1;
            end
        end
    end

    // largest aligned block that still fits
    always_comb
    begin
        carve_o = '0;
        for (int o = 0; o <= MAX_ORDER; o++)
        begin
            if ((CNT_W'(1) << o) <= rem &&
                (pos_reg & ((CNT_W'(1) << o) - CNT_W'(1))) == '0)
                carve_o = ORD_W'(o);
        end
    end

    always_comb
    begin
        pre_status = ST_OK;
        case (cmd_reg)
            CMD_INIT:
                if (size_clamp < CNT_W'(2))
                    pre_status = ST_BAD_INDEX;
            CMD_ALLOC:
                if (!ready_reg)
                    pre_status = ST_NOT_INIT;
                else if (ord_reg > ORD_W'(MAX_ORDER))
                    pre_status = ST_BAD_ORDER;
                else if (!found_any)
                    pre_status = ST_NO_MEM;
            CMD_FREE:
                if (!ready_reg)
                    pre_status = ST_NOT_INIT;
                else if (ord_reg > ORD_W'(MAX_ORDER))
                    pre_status = ST_BAD_ORDER;
                else if ({1'b0, idx_reg} >= region_reg || (idx_reg & ord_mask) != '0)
                    pre_status = ST_BAD_INDEX;
            default:
                pre_status = ST_OK;
        endcase
    end

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.pre_ok     = (pre_status == ST_OK) && (cmd_reg != CMD_NOP);
        stat.clr_last   = (cnt_reg == CNT_W'(BLOCK_COUNT - 1));
        stat.carve_end  = (pos_reg >= size_reg);
        stat.split_more = (lvl_reg > ord_reg);
        stat.map_last   = (cnt_reg == n_ord - CNT_W'(1));
        stat.merge_top  = (lvl_reg == ORD_W'(MAX_ORDER)) || ({1'b0, bud} >= region_reg);
        stat.scan_done  = (cnt_reg == n_lvl) && !pend_reg;
        stat.scan_hit   = hit_reg;
        stat.tag_match  = (rd_tag_reg == TAG_W'(lvl_reg + ORD_W'(1)));
    end

    // memory ports
    always_comb
    begin
        nx_we   = 1'b0;
        nx_wa   = '0;
        nx_wd   = '0;
        pv_we   = 1'b0;
        pv_wa   = '0;
        pv_wd   = '0;
        tag_we  = 1'b0;
        tag_wa  = '0;
        tag_wd  = '0;
        map_we  = 1'b0;
        map_wa  = '0;
        map_wd  = 1'b0;
        rd_en   = 1'b0;
        rd_addr = '0;
        map_re  = 1'b0;
        map_ra  = '0;
        case (op)
            OP_START:
            begin
                rd_en   = 1'b1;
                rd_addr = head_reg[found_c][IDX_W-1:0];
            end
            OP_CLEAR:
            begin
                tag_we = 1'b1;
                tag_wa = cnt_reg[IDX_W-1:0];
                map_we = 1'b1;
                map_wa = cnt_reg[IDX_W-1:0];
            end
            OP_CARVE:
            begin
                rd_en   = 1'b1;
                rd_addr = pos_reg[IDX_W-1:0];
            end
            OP_SPLIT:
            begin
                rd_en   = 1'b1;
                rd_addr = split_b;
            end
            OP_FIN:
            begin
                rd_en   = 1'b1;
                rd_addr = blk_reg;
            end
            OP_TAG_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = bud;
            end
            OP_APP_UNL, OP_UNLINK, OP_MERGE:
            begin
                if (ul_valid)
                begin
                    if (rd_prev_reg != NIL_LINK)
                    begin
                        nx_we = 1'b1;
                        nx_wa = rd_prev_reg[IDX_W-1:0];
                        nx_wd = rd_next_reg;
                    end
                    if (rd_next_reg != NIL_LINK)
                    begin
                        pv_we = 1'b1;
                        pv_wa = rd_next_reg[IDX_W-1:0];
                        pv_wd = rd_prev_reg;
                    end
                    tag_we = 1'b1;
                    tag_wa = rd_b_reg;
                end
            end
            OP_APP_LINK:
            begin
                pv_we  = 1'b1;
                pv_wa  = app_b_reg;
                pv_wd  = tail_reg[app_o_reg];
                nx_we  = 1'b1;
                nx_wa  = app_b_reg;
                nx_wd  = NIL_LINK;
                tag_we = 1'b1;
                tag_wa = app_b_reg;
                tag_wd = TAG_W'(app_o_reg + ORD_W'(1));
            end
            OP_APP_TAIL:
            begin
                if (tail_t_reg != NIL_LINK)
                begin
                    nx_we = 1'b1;
                    nx_wa = tail_t_reg[IDX_W-1:0];
                    nx_wd = {1'b0, app_b_reg};
                end
            end
            OP_MAPSET:
            begin
                map_we = 1'b1;
                map_wa = blk_reg + cnt_reg[IDX_W-1:0];
                map_wd = (cmd_reg == CMD_ALLOC);
            end
            OP_SCAN:
            begin
                if (cnt_reg < n_lvl)
                begin
                    map_re = 1'b1;
                    map_ra = bud + cnt_reg[IDX_W-1:0];
                end
            end
            default:
                nx_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
            next_mem[nx_wa] <= nx_wd;
        if (pv_we)
            prev_mem[pv_wa] <= pv_wd;
        if (tag_we)
            tag_mem[tag_wa] <= tag_wd;
        if (map_we)
            map_mem[map_wa] <= map_wd;
        if (rd_en)
        begin
            rd_next_reg <= next_mem[rd_addr];
            rd_prev_reg <= prev_mem[rd_addr];
            rd_tag_reg  <= tag_mem[rd_addr];
            rd_b_reg    <= rd_addr;
        end
        if (map_re)
            map_rd_reg <= map_mem[map_ra];
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (op == OP_OUT)
        begin
            out_status_reg <= status_reg;
            out_result_reg <= result_reg;
            out_free_reg   <= free_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mb_reg     <= CNT_W'(BLOCK_COUNT);
            cmd_reg    <= CMD_NOP;
            ord_reg    <= '0;
            idx_reg    <= '0;
            blk_reg    <= '0;
            app_b_reg  <= '0;
            lvl_reg    <= '0;
            app_o_reg  <= '0;
            pos_reg    <= '0;
            size_reg   <= '0;
            cnt_reg    <= '0;
            tail_t_reg <= NIL_LINK;
            region_reg <= '0;
            free_reg   <= '0;
            pend_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            ready_reg  <= 1'b0;
            status_reg <= ST_OK;
            result_reg <= '0;
            for (int o = 0; o < NUM_LISTS; o++)
            begin
                head_reg[o] <= NIL_LINK;
                tail_reg[o] <= NIL_LINK;
            end
        end
        else
        begin
            if (cfg_valid)
                mb_reg <= managed_blocks;
            case (op)
                OP_LOAD:
                begin
                    cmd_reg <= cmd_t'(cmd);
                    ord_reg <= order;
                    idx_reg <= block_index;
                end
                OP_START:
                begin
                    status_reg <= pre_status;
                    result_reg <= '0;
                    if (stat.pre_ok)
                    begin
                        case (cmd_reg)
                            CMD_INIT:
                            begin
                                cnt_reg  <= '0;
                                size_reg <= size_clamp;
                                for (int o = 0; o < NUM_LISTS; o++)
                                begin
                                    head_reg[o] <= NIL_LINK;
                                    tail_reg[o] <= NIL_LINK;
                                end
                            end
                            CMD_ALLOC:
                            begin
                                lvl_reg <= found_c;
                                blk_reg <= head_reg[found_c][IDX_W-1:0];
                            end
                            default:
                            begin
                                blk_reg <= idx_reg;
                                lvl_reg <= ord_reg;
                                cnt_reg <= '0;
                            end
                        endcase
                    end
                end
                OP_CLEAR:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (stat.clr_last)
                        pos_reg <= '0;
                end
                OP_CARVE:
                begin
                    app_b_reg <= pos_reg[IDX_W-1:0];
                    app_o_reg <= carve_o;
                    pos_reg   <= pos_reg + (CNT_W'(1) << carve_o);
                end
                OP_INIT_END:
                begin
                    region_reg <= size_reg;
                    free_reg   <= size_reg;
                    ready_reg  <= 1'b1;
                end
                OP_APP_UNL, OP_UNLINK, OP_MERGE:
                begin
                    if (ul_valid)
                    begin
                        if (rd_prev_reg == NIL_LINK)
                            head_reg[ul_o] <= rd_next_reg;
                        if (rd_next_reg == NIL_LINK)
                            tail_reg[ul_o] <= rd_prev_reg;
                    end
                    if (op == OP_MERGE)
                    begin
                        blk_reg <= blk_reg & ~IDX_W'(n_lvl);
                        lvl_reg <= lvl_reg + ORD_W'(1);
                    end
                end
                OP_APP_LINK:
                begin
                    tail_t_reg <= tail_reg[app_o_reg];
                    if (tail_reg[app_o_reg] == NIL_LINK)
                        head_reg[app_o_reg] <= {1'b0, app_b_reg};
                    tail_reg[app_o_reg] <= {1'b0, app_b_reg};
                end
                OP_SPLIT:
                begin
                    lvl_reg   <= lvl_reg - ORD_W'(1);
                    app_b_reg <= split_b;
                    app_o_reg <= lvl_reg - ORD_W'(1);
                end
                OP_MAP_START:
                begin
                    cnt_reg    <= '0;
                    result_reg <= blk_reg;
                end
                OP_MAPSET:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (stat.map_last)
                    begin
                        if (cmd_reg == CMD_ALLOC)
                            free_reg <= (free_reg > n_ord) ? free_reg - n_ord : '0;
                        else if (free_sum > {1'b0, region_reg})
                            free_reg <= region_reg;
                        else
                            free_reg <= free_sum[CNT_W-1:0];
                    end
                end
                OP_FIN:
                begin
                    app_b_reg <= blk_reg;
                    app_o_reg <= lvl_reg;
                end
                OP_SCAN_START:
                begin
                    cnt_reg  <= '0;
                    pend_reg <= 1'b0;
                    hit_reg  <= 1'b0;
                end
                OP_SCAN:
                begin
                    if (cnt_reg < n_lvl)
                    begin
                        cnt_reg  <= cnt_reg + CNT_W'(1);
                        pend_reg <= 1'b1;
                    end
                    else
                        pend_reg <= 1'b0;
                    if (pend_reg && map_rd_reg)
                        hit_reg <= 1'b1;
                end
                default:
                    pend_reg <= pend_reg;
            endcase
        end
    end

    assign status       = out_status_reg;
    assign result_index = out_result_reg;
    assign free_units   = out_free_reg;

endmodule

FILE: design/bba_checker.sv
// Port-level checker for the buddy block allocator, bound to the top level.
module bba_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bba_pkg::STAT_W-1:0]    status,
    input logic [bba_pkg::IDX_W-1:0]     result_index,
    input logic [bba_pkg::CNT_W-1:0]     free_units
);
    import bba_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(result_index) && $stable(free_units))
        else $error("output word changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_BAD_INDEX)
        else $error("status code out of range");

    a_fail_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> result_index == '0)
        else $error("nonzero index on failed command");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> free_units <= CNT_W'(BLOCK_COUNT))
        else $error("free count above region limit");

    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command accepted on consecutive cycles");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);
